// ===== rtl/dfbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbs_pkg
// Shared sizes, codes and interface types of the dual free-buffer stack.
// ----------------------------------------------------------------------------
package dfbs_pkg;

  // Sizes
  localparam int ADDR_BITS    = 48;
  localparam int POOL_DEPTH   = 256;
  localparam int RES_DEPTH    = 16;
  localparam int MAX_BATCH    = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int BATCH_LIMIT  = (MAX_BATCH < RESULT_LIMIT) ? MAX_BATCH : RESULT_LIMIT;

  localparam int POOL_AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int POOL_CW = $clog2(POOL_DEPTH + 1);
  localparam int RES_AW  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int RES_CW  = $clog2(RES_DEPTH + 1);

  localparam int IDX_W       = 6;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC_MAIN = 2'd0,
    FN_ALLOC_RES  = 2'd1,
    FN_FREE       = 2'd2,
    FN_BATCH      = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RES_BASE  = 1'b0,
    CFG_ADDR_MASK = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLY,
    S_EMIT
  } state_t;

  // Memory port requests
  typedef struct packed {
    logic                 we;
    logic [POOL_AW-1:0]   waddr;
    logic [ADDR_BITS-1:0] wdata;
    logic                 re;
    logic [POOL_AW-1:0]   raddr;
  } pool_req_t;

  typedef struct packed {
    logic                 we;
    logic [RES_AW-1:0]    waddr;
    logic [ADDR_BITS-1:0] wdata;
    logic                 re;
    logic [RES_AW-1:0]    raddr;
  } res_req_t;

endpackage

// ===== rtl/dfbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dfbs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dfbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbs_ctrl
// Stack sequencer: stack pointers, config registers, push/pop control and
// the registered result stage.
// ----------------------------------------------------------------------------
module dfbs_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_wr_en,
  input  logic [dfbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dfbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // request
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dfbs_pkg::FUNC_W-1:0]         in_func,
  input  logic [dfbs_pkg::ADDR_BITS-1:0]      in_addr,
  // memories
  output dfbs_pkg::pool_req_t                 pool_req,
  input  logic [dfbs_pkg::ADDR_BITS-1:0]      pool_rdata,
  output dfbs_pkg::res_req_t                  res_req,
  input  logic [dfbs_pkg::ADDR_BITS-1:0]      res_rdata,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dfbs_pkg::ADDR_BITS-1:0]      out_addr,
  output logic [dfbs_pkg::STATUS_W-1:0]       out_status,
  output logic [dfbs_pkg::IDX_W-1:0]          out_index,
  output logic                                out_last
);

  dfbs_pkg::state_t                    state_r, state_nxt;
  logic [dfbs_pkg::POOL_CW-1:0]        pool_cnt_r, pool_cnt_nxt;
  logic [dfbs_pkg::RES_CW-1:0]         res_cnt_r, res_cnt_nxt;
  dfbs_pkg::status_t                   reply_r, reply_nxt;
  logic                                src_res_r, src_res_nxt;
  logic                                batch_r, batch_nxt;
  logic [dfbs_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [dfbs_pkg::ADDR_BITS-1:0]      base_r, mask_r;

  logic                                out_valid_r, out_valid_nxt;
  logic [dfbs_pkg::ADDR_BITS-1:0]      out_addr_r, out_addr_nxt;
  dfbs_pkg::status_t                   out_status_r, out_status_nxt;
  logic [dfbs_pkg::IDX_W-1:0]          out_index_r, out_index_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                                accept;
  logic                                out_free;
  logic                                out_load;
  logic [dfbs_pkg::ADDR_BITS-1:0]      free_addr;
  logic                                to_res;
  logic                                pool_empty, pool_full, res_empty, res_full;
  logic                                emit_last;
  logic [dfbs_pkg::POOL_CW-1:0]        pool_top;
  logic [dfbs_pkg::RES_CW-1:0]         res_top;
  dfbs_pkg::func_t                     func;

  assign func       = dfbs_pkg::func_t'(in_func);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_ready;
  assign free_addr  = in_addr & mask_r;
  assign to_res     = (free_addr >= base_r);
  assign pool_empty = (pool_cnt_r == '0);
  assign res_empty  = (res_cnt_r == '0);
  assign pool_full  = (pool_cnt_r == dfbs_pkg::POOL_CW'(dfbs_pkg::POOL_DEPTH));
  assign res_full   = (res_cnt_r == dfbs_pkg::RES_CW'(dfbs_pkg::RES_DEPTH));
  assign pool_top   = pool_cnt_r - 1'b1;
  assign res_top    = res_cnt_r - 1'b1;

  // A single pop always ends at once; a batch ends at its length limit or when the main stack has drained
  assign emit_last = !batch_r || pool_empty ||
                     (idx_r == dfbs_pkg::IDX_W'(dfbs_pkg::BATCH_LIMIT - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfbs_pkg::S_IDLE: begin
        if (accept) begin
          case (func)
            dfbs_pkg::FN_ALLOC_MAIN,
            dfbs_pkg::FN_BATCH:     state_nxt = pool_empty ? dfbs_pkg::S_REPLY
                                                           : dfbs_pkg::S_EMIT;
            dfbs_pkg::FN_ALLOC_RES: state_nxt = res_empty ? dfbs_pkg::S_REPLY
                                                          : dfbs_pkg::S_EMIT;
            default:                state_nxt = dfbs_pkg::S_REPLY;
          endcase
        end
      end
      dfbs_pkg::S_REPLY: begin
        if (out_free) state_nxt = dfbs_pkg::S_IDLE;
      end
      dfbs_pkg::S_EMIT: begin
        if (out_free && emit_last) state_nxt = dfbs_pkg::S_IDLE;
      end
      default: state_nxt = dfbs_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    in_tready      = (state_r == dfbs_pkg::S_IDLE);
    pool_req       = '0;
    res_req        = '0;
    pool_cnt_nxt   = pool_cnt_r;
    res_cnt_nxt    = res_cnt_r;
    reply_nxt      = reply_r;
    src_res_nxt    = src_res_r;
    batch_nxt      = batch_r;
    idx_nxt        = idx_r;
    out_load       = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;

    pool_req.waddr = pool_cnt_r[dfbs_pkg::POOL_AW-1:0];
    pool_req.wdata = free_addr;
    pool_req.raddr = pool_top[dfbs_pkg::POOL_AW-1:0];
    res_req.waddr  = res_cnt_r[dfbs_pkg::RES_AW-1:0];
    res_req.wdata  = free_addr;
    res_req.raddr  = res_top[dfbs_pkg::RES_AW-1:0];

    case (state_r)
      dfbs_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt     = '0;
          batch_nxt   = (func == dfbs_pkg::FN_BATCH);
          src_res_nxt = (func == dfbs_pkg::FN_ALLOC_RES);
          case (func)
            dfbs_pkg::FN_ALLOC_MAIN,
            dfbs_pkg::FN_BATCH: begin
              if (pool_empty) begin
                reply_nxt = dfbs_pkg::STS_EMPTY;
              end else begin
                pool_req.re  = 1'b1;
                pool_cnt_nxt = pool_top;
              end
            end
            dfbs_pkg::FN_ALLOC_RES: begin
              if (res_empty) begin
                reply_nxt = dfbs_pkg::STS_EMPTY;
              end else begin
                res_req.re  = 1'b1;
                res_cnt_nxt = res_top;
              end
            end
            default: begin
              // free: push onto the stack the masked address belongs to
              if (to_res) begin
                if (res_full) begin
                  reply_nxt = dfbs_pkg::STS_FULL;
                end else begin
                  res_req.we  = 1'b1;
                  res_cnt_nxt = res_cnt_r + 1'b1;
                  reply_nxt   = dfbs_pkg::STS_OK;
                end
              end else begin
                if (pool_full) begin
                  reply_nxt = dfbs_pkg::STS_FULL;
                end else begin
                  pool_req.we  = 1'b1;
                  pool_cnt_nxt = pool_cnt_r + 1'b1;
                  reply_nxt    = dfbs_pkg::STS_OK;
                end
              end
            end
          endcase
        end
      end
      dfbs_pkg::S_REPLY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = reply_r;
          out_index_nxt  = '0;
          out_last_nxt   = 1'b1;
        end
      end
      dfbs_pkg::S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_addr_nxt   = src_res_r ? res_rdata : pool_rdata;
          out_status_nxt = dfbs_pkg::STS_OK;
          out_index_nxt  = idx_r;
          out_last_nxt   = emit_last;
          // keep popping the main stack, one entry per cycle while the result register is free
          if (!emit_last) begin
            pool_req.re  = 1'b1;
            pool_cnt_nxt = pool_top;
            idx_nxt      = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result stage valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfbs_pkg::S_IDLE;
      pool_cnt_r  <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      mask_r      <= '1;
    end else begin
      state_r     <= state_nxt;
      pool_cnt_r  <= pool_cnt_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (dfbs_pkg::cfg_reg_t'(cfg_index))
          dfbs_pkg::CFG_RES_BASE:  base_r <= cfg_wdata;
          dfbs_pkg::CFG_ADDR_MASK: mask_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    reply_r   <= reply_nxt;
    src_res_r <= src_res_nxt;
    batch_r   <= batch_nxt;
    idx_r     <= idx_nxt;
    if (out_load) begin
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;

  // Checks
  a_pool_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pool_cnt_r <= dfbs_pkg::POOL_CW'(dfbs_pkg::POOL_DEPTH))
    else $error("pool count beyond depth");

  a_res_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= dfbs_pkg::RES_CW'(dfbs_pkg::RES_DEPTH))
    else $error("reserved count beyond depth");

  a_no_pool_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(pool_req.we && pool_req.re))
    else $error("pool read and write in one cycle");

  a_batch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfbs_pkg::S_EMIT) |->
      (idx_r < dfbs_pkg::IDX_W'(dfbs_pkg::BATCH_LIMIT)))
    else $error("batch index past limit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == dfbs_pkg::S_IDLE))
    else $error("sequencer busy after final result");

endmodule

// ===== rtl/dual_free_buffer_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_free_buffer_stack
// Two LIFO free lists of buffer addresses (main pool and reserved pool),
// each held in a synchronous RAM with a stack pointer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | sink      | tvalid/tready      | tuser func, tdata buffer_addr
//  out_    | source    | tvalid/tready      | tdata addr+index, tuser status,
//          |           |                    | tlast last
//  cfg_    | sink      | wr_en, no wait     | index, 48-bit data
//
//  A batch returns one result per cycle after the first read, as long as
//  out_tready does not stall it. The stack RAMs have a registered read
//  port, so each popped address is read before it reaches the result.
//  Reset (rst_n low, synchronous) empties both stacks; RAM contents are kept.
//  A stalled out_tready holds the result register and the sequencer; a new
//  item is taken only once all results of the previous one are registered.
// ----------------------------------------------------------------------------
module dual_free_buffer_stack (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [dfbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dfbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // requests
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dfbs_pkg::IN_TDATA_W-1:0]      in_tdata,   // [47:0] buffer_addr
  input  logic [dfbs_pkg::FUNC_W-1:0]          in_tuser,   // [1:0] func
  // results
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dfbs_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [47:0] out_addr,
                                                           // [53:48] batch_index
  output logic [dfbs_pkg::STATUS_W-1:0]        out_tuser,  // [1:0] status
  output logic                                 out_tlast
);

  dfbs_pkg::pool_req_t                 pool_req;
  dfbs_pkg::res_req_t                  res_req;
  logic [dfbs_pkg::ADDR_BITS-1:0]      pool_rdata;
  logic [dfbs_pkg::ADDR_BITS-1:0]      res_rdata;
  logic [dfbs_pkg::ADDR_BITS-1:0]      res_addr;
  logic [dfbs_pkg::IDX_W-1:0]          res_index;

  // Main pool stack memory
  dfbs_ram #(
    .DEPTH (dfbs_pkg::POOL_DEPTH),
    .WIDTH (dfbs_pkg::ADDR_BITS),
    .AW    (dfbs_pkg::POOL_AW)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_req.we),
    .waddr (pool_req.waddr),
    .wdata (pool_req.wdata),
    .re    (pool_req.re),
    .raddr (pool_req.raddr),
    .rdata (pool_rdata)
  );

  // Reserved pool stack memory
  dfbs_ram #(
    .DEPTH (dfbs_pkg::RES_DEPTH),
    .WIDTH (dfbs_pkg::ADDR_BITS),
    .AW    (dfbs_pkg::RES_AW)
  ) u_res_ram (
    .clk   (clk),
    .we    (res_req.we),
    .waddr (res_req.waddr),
    .wdata (res_req.wdata),
    .re    (res_req.re),
    .raddr (res_req.raddr),
    .rdata (res_rdata)
  );

  // Sequencer and result register
  dfbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .in_addr    (in_tdata[dfbs_pkg::ADDR_BITS-1:0]),
    .pool_req   (pool_req),
    .pool_rdata (pool_rdata),
    .res_req    (res_req),
    .res_rdata  (res_rdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (res_addr),
    .out_status (out_tuser),
    .out_index  (res_index),
    .out_last   (out_tlast)
  );

  // Pack result fields, zero pad to whole bytes
  assign out_tdata = {
    {(dfbs_pkg::OUT_TDATA_W - dfbs_pkg::ADDR_BITS - dfbs_pkg::IDX_W){1'b0}},
    res_index,
    res_addr
  };

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual free-buffer stack. A short scripted
// sequence covers empty pops, reserved overflow, masking and the base compare.
// Random traffic then runs under several register settings. Each request is
// mirrored in a model of both free lists, and every returned item is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  import dfbs_pkg::*;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    status_t              sts;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } result_t;

  // one line of the scripted sequence: a register write or a repeated request
  typedef struct {
    bit                   is_cfg;
    cfg_reg_t             which;
    func_t                fn;
    logic [ADDR_BITS-1:0] value;
    int unsigned          reps;
    bit                   typed;
    status_t              want_sts;
    logic [ADDR_BITS-1:0] want_addr;
  } script_row_t;

  typedef enum {MIX_ALL, FILL_FREES, DRAIN_POPS} traffic_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_TDATA_W-1:0]      in_tdata = '0;   // [47:0] buffer_addr
  logic [FUNC_W-1:0]          in_tuser = '0;   // [1:0] func
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]     out_tdata;       // [47:0] out_addr, [53:48] batch_index
  logic [STATUS_W-1:0]        out_tuser;       // [1:0] status
  logic                       out_tlast;

  // mirror of the block state
  logic [ADDR_BITS-1:0] free_main [POOL_DEPTH];
  logic [ADDR_BITS-1:0] free_resv [RES_DEPTH];
  int                   main_depth = 0;
  int                   resv_depth = 0;
  logic [ADDR_BITS-1:0] resv_base = '0;
  logic [ADDR_BITS-1:0] addr_mask = '1;

  result_t     awaited_results [$];
  script_row_t script [$];
  result_t     want;
  int          errors = 0;
  bit          steady = 1'b0;

  dual_free_buffer_stack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // pops and pushes of both free lists for one accepted item
  function automatic void predict_results(func_t fn, logic [ADDR_BITS-1:0] addr, bit typed,
                                          status_t want_sts, logic [ADDR_BITS-1:0] want_addr);
    result_t              made [$];
    logic [ADDR_BITS-1:0] kept;
    int                   n;
    kept = addr & addr_mask;
    case (fn)
      FN_ALLOC_MAIN: begin
        if (main_depth == 0) begin
          made.push_back('{'0, STS_EMPTY, '0, 1'b1});
        end else begin
          main_depth--;
          made.push_back('{free_main[main_depth], STS_OK, '0, 1'b1});
        end
      end
      FN_ALLOC_RES: begin
        if (resv_depth == 0) begin
          made.push_back('{'0, STS_EMPTY, '0, 1'b1});
        end else begin
          resv_depth--;
          made.push_back('{free_resv[resv_depth], STS_OK, '0, 1'b1});
        end
      end
      FN_FREE: begin
        if (kept >= resv_base) begin
          if (resv_depth >= RES_DEPTH) begin
            made.push_back('{'0, STS_FULL, '0, 1'b1});
          end else begin
            free_resv[resv_depth] = kept;
            resv_depth++;
            made.push_back('{'0, STS_OK, '0, 1'b1});
          end
        end else begin
          if (main_depth >= POOL_DEPTH) begin
            made.push_back('{'0, STS_FULL, '0, 1'b1});
          end else begin
            free_main[main_depth] = kept;
            main_depth++;
            made.push_back('{'0, STS_OK, '0, 1'b1});
          end
        end
      end
      default: begin
        // batch pop from the main list, last flag on the final item
        if (main_depth == 0) begin
          made.push_back('{'0, STS_EMPTY, '0, 1'b1});
        end else begin
          n = 0;
          while (n < BATCH_LIMIT && main_depth > 0) begin
            main_depth--;
            made.push_back('{free_main[main_depth], STS_OK, IDX_W'(n), 1'b0});
            n++;
          end
          made[made.size()-1].last = 1'b1;
        end
      end
    endcase
    if (typed) begin
      awaited_results.push_back('{want_addr, want_sts, '0, 1'b1});
    end else begin
      foreach (made[i]) awaited_results.push_back(made[i]);
    end
  endfunction

  // send one item, then record what it should return
  task automatic issue_request(input func_t fn, input logic [ADDR_BITS-1:0] addr, input bit typed,
                               input status_t want_sts, input logic [ADDR_BITS-1:0] want_addr);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_results(fn, addr, typed, want_sts, want_addr);
  endtask

  // register write, only once all outstanding items are back
  task automatic write_register(input cfg_reg_t which, input logic [ADDR_BITS-1:0] value);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (which == CFG_RES_BASE) resv_base = value;
    else addr_mask = value;
  endtask

  function automatic void add_cfg(cfg_reg_t which, logic [ADDR_BITS-1:0] value);
    script.push_back('{1'b1, which, FN_FREE, value, 1, 1'b0, STS_OK, '0});
  endfunction

  function automatic void add_req(func_t fn, logic [ADDR_BITS-1:0] addr, int unsigned reps,
                                  bit typed, status_t want_sts = STS_OK,
                                  logic [ADDR_BITS-1:0] want_addr = '0);
    script.push_back('{1'b0, CFG_RES_BASE, fn, addr, reps, typed, want_sts, want_addr});
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 32);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected item: addr=%h status=%0d index=%0d last=%b", $time,
                 out_tdata[47:0], out_tuser, out_tdata[53:48], out_tlast);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[47:0] !== want.addr || out_tuser !== want.sts ||
            out_tdata[53:48] !== want.idx || out_tlast !== want.last) begin
          $display("%0t: mismatch: expected addr=%h status=%0d index=%0d last=%b", $time,
                   want.addr, want.sts, want.idx, want.last);
          $display("%0t:           actual addr=%h status=%0d index=%0d last=%b", $time,
                   out_tdata[47:0], out_tuser, out_tdata[53:48], out_tlast);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    func_t                fn;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] mask;
    traffic_t             mode;
    int                   len;
    int                   sent;
    int                   r;

    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // scripted sequence
    add_req(FN_ALLOC_MAIN, '0, 1, 1'b1, STS_EMPTY, '0);
    add_req(FN_ALLOC_RES,  '0, 1, 1'b1, STS_EMPTY, '0);
    add_req(FN_BATCH,      '0, 1, 1'b1, STS_EMPTY, '0);
    add_req(FN_FREE, 48'h0000_0000_0010, 1, 1'b1, STS_OK, '0);      // base 0: reserved
    add_req(FN_ALLOC_RES,  '0, 1, 1'b1, STS_OK, 48'h0000_0000_0010);
    add_cfg(CFG_RES_BASE, 48'h8000_0000_0000);
    add_req(FN_FREE, 48'hFFFF_FFFF_FFFF, RES_DEPTH, 1'b1, STS_OK, '0);
    add_req(FN_FREE, 48'hFFFF_FFFF_FFFF, 1, 1'b1, STS_FULL, '0);    // reserved overflow
    add_req(FN_ALLOC_RES, 48'hFFFF_FFFF_FFFF, 1, 1'b1, STS_OK, 48'hFFFF_FFFF_FFFF);
    add_req(FN_FREE, 48'h0000_0000_0000, 1, 1'b1, STS_OK, '0);
    add_req(FN_FREE, 48'h7FFF_FFFF_FFFF, 1, 1'b1, STS_OK, '0);      // just below base
    add_cfg(CFG_ADDR_MASK, 48'h0000_FFFF_FFFF);
    add_req(FN_FREE, 48'hF000_0000_1234, 1, 1'b0);                  // flag bits stripped
    add_req(FN_FREE, 48'hAAAA_5555_AAAA, 1, 1'b0);
    add_req(FN_BATCH, 48'h0000_0000_0005, 1, 1'b0);                 // address ignored
    add_req(FN_ALLOC_MAIN, '0, 1, 1'b1, STS_EMPTY, '0);
    add_req(FN_ALLOC_RES, '0, 1, 1'b0);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_register(script[i].which, script[i].value);
      end else begin
        repeat (script[i].reps)
          issue_request(script[i].fn, script[i].value, script[i].typed,
                        script[i].want_sts, script[i].want_addr);
      end
    end

    // random traffic, one register setting per phase
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          base = 48'h8000_0000_0000; mask = '1; mode = MIX_ALL; len = 60;
        end
        1: begin
          // nearly every free lands in the main list until it overflows
          base = '1; mask = '1; mode = FILL_FREES; len = 300;
        end
        2: begin
          base = '0; mask = 48'h0000_0000_FFFF; mode = DRAIN_POPS; len = 80;
        end
        default: begin
          base = 48'h0000_8000_0000; mask = '0; mode = MIX_ALL; len = 40;
        end
      endcase
      write_register(CFG_RES_BASE, base);
      write_register(CFG_ADDR_MASK, mask);
      for (int k = 0; k < len; k++) begin
        steady = (sent >= 100 && sent < 200);
        r = $urandom_range(0, 99);
        case (mode)
          MIX_ALL:    fn = func_t'($urandom_range(0, 3));
          FILL_FREES: fn = (r < 95) ? FN_FREE : func_t'($urandom_range(0, 1));
          default: begin
            if (r < 45)      fn = FN_BATCH;
            else if (r < 75) fn = FN_ALLOC_MAIN;
            else if (r < 85) fn = FN_ALLOC_RES;
            else             fn = FN_FREE;
          end
        endcase
        addr = ADDR_BITS'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        // hit the base boundary now and then
        if (r < 10)      addr = resv_base;
        else if (r < 20) addr = resv_base - 1'b1;
        issue_request(fn, addr, 1'b0, STS_OK, '0);
        sent++;
      end
    end
    steady = 1'b0;

    // drain and finish
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dfbs_pkg.sv
rtl/dfbs_ram.sv
rtl/dfbs_ctrl.sv
rtl/dual_free_buffer_stack.sv
verif/testbench.sv
